// ===== rtl/uvs_pkg.sv =====
// shared constants, types and rounding helpers for the uv sphere vertex generator
package uvs_pkg;

  // segment count limits
  localparam int unsigned MAX_SEGMENTS = 255;
  localparam int unsigned MIN_WIDTH_SEG = 3;
  localparam int unsigned MIN_HEIGHT_SEG = 2;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH_SEG = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SEG = 2'd2;

  // reset values
  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [7:0] WIDTH_SEG_RST = 8'd8;
  localparam logic [7:0] HEIGHT_SEG_RST = 8'd6;

  // angle divider: 24 bit numerator, 8 bit divisor, two quotient bits per stage
  localparam int DIV_NUM_W = 24;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS_PER_STAGE;

  // trig pipeline: 3 setup stages, 3 per horner step, 2 finishing stages
  localparam int HORNER_STEPS = 6;
  localparam int SIN_STEPS = 5;
  localparam int TRIG_STAGES = 3 + 3 * HORNER_STEPS + 2;

  typedef logic signed [31:0] q30_t;

  localparam q30_t ONE_Q30 = 32'sh4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // horner denominators split as odd * 2^shift, odd part divided by reciprocal
  // cos: 132 90 56 30 12 2, sin: 110 72 42 20 6 (last sin slot unused)
  localparam int COS_SHIFT [HORNER_STEPS] = '{2, 1, 3, 1, 2, 1};
  localparam int COS_ODD [HORNER_STEPS] = '{33, 45, 7, 15, 3, 1};
  localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
    32'd130150524, 32'd95443717, 32'd613566756,
    32'd286331153, 32'd1431655765, 32'hFFFF_FFFF};
  localparam int SIN_SHIFT [HORNER_STEPS] = '{1, 3, 1, 2, 1, 0};
  localparam int SIN_ODD [HORNER_STEPS] = '{55, 9, 21, 5, 3, 1};
  localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
    32'd78090314, 32'd477218588, 32'd204522252,
    32'd858993459, 32'd1431655765, 32'hFFFF_FFFF};

  // mesh indices and triangle flags that ride alongside the arithmetic
  typedef struct packed {
    logic [15:0] idx_top_left;
    logic [15:0] idx_top_right;
    logic [15:0] idx_bottom_left;
    logic [15:0] idx_bottom_right;
    logic        upper_tri_valid;
    logic        lower_tri_valid;
  } uvs_side_t;

  // round half away from zero, shift by 30
  function automatic logic signed [63:0] rnd_shift30(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'h2000_0000) >> 30;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // round half away from zero, shift by 16
  function automatic logic signed [63:0] rnd_shift16(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'h0000_8000) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/uv_sphere_vertex_generator.sv =====
// top level of the uv sphere vertex generator: config, angle, trig and scaling pipeline
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  grid point (column, row)
// m_axis    out        m_axis_tvalid/m_axis_tready  position, normal, cell indices, flags
// cfg       in         cfg_valid/cfg_ready          register index and write data
//
// one grid point per cycle unless stalled; each point passes the entry stage,
// the 12-stage angle divider, 23-stage taylor trig pipeline and post stages in series
// the whole pipeline moves on one enable: it stalls only when a result sits in the
// output register and m_axis_tready is low, and bubbles are filled while it runs
// rst is synchronous: it clears every valid bit and loads radius 1.0, 8 by 6 segments
// cfg_ready is always high; registers may be written only with the pipeline empty
module uv_sphere_vertex_generator (
  input  logic         clk,
  input  logic         rst,
  // grid_col [7:0], grid_row [15:8]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,
  // pos_x [16:0], pos_y [33:17], pos_z [50:34], norm_x [66:51], norm_y [82:67],
  // norm_z [98:83], idx_top_left [114:99], idx_top_right [130:115],
  // idx_bottom_left [146:131], idx_bottom_right [162:147], upper_tri_valid [163],
  // lower_tri_valid [164], zero fill [167:165]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import uvs_pkg::*;

  // sideband delay, aligned with the third post stage
  localparam int SB_LEN = DIV_STAGES + TRIG_STAGES + 3;

  // configuration registers
  logic [15:0] radius;
  logic [7:0]  width_segments;
  logic [7:0]  height_segments;

  logic en;

  // entry stage
  logic       e_valid;
  logic [7:0] e_col, e_row, e_w, e_h;
  logic [7:0] w_c, h_c, col_c, row_c;

  // angle and trig outputs
  logic        phi_dv, th_dv, phi_tv, th_tv, t_valid;
  logic [15:0] phi, theta;
  q30_t        sp, cp, st, ct;

  // sideband
  uvs_side_t side_next;
  uvs_side_t sb [SB_LEN];
  logic [8:0] wp1;
  logic [7:0] colr, rowd;
  logic       in_cell;

  // post stages
  logic signed [16:0] rad_s;
  logic               p1_valid, p2_valid, p3_valid, p4_valid;
  logic signed [63:0] p1_cst, p1_sst, p1_ctr;
  q30_t               p1_ct, p2_ct;
  q30_t               p2_px, p2_pz;
  logic signed [16:0] p2_posy, p3_posy;
  logic signed [63:0] p3_pxr, p3_pzr;
  logic signed [15:0] p3_nx, p3_ny, p3_nz;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  uvs_side_t          out_side;

  // register writes, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius          <= RADIUS_RST;
      width_segments  <= WIDTH_SEG_RST;
      height_segments <= HEIGHT_SEG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS:     radius <= cfg_data;
        REG_WIDTH_SEG:  width_segments <= cfg_data[7:0];
        REG_HEIGHT_SEG: height_segments <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // global advance: stall only when the output register is full and blocked
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // clamp segment counts, saturate the grid point
  always_comb begin
    if (width_segments < 8'(MIN_WIDTH_SEG)) begin
      w_c = 8'(MIN_WIDTH_SEG);
    end else if (width_segments > 8'(MAX_SEGMENTS)) begin
      w_c = 8'(MAX_SEGMENTS);
    end else begin
      w_c = width_segments;
    end
    if (height_segments < 8'(MIN_HEIGHT_SEG)) begin
      h_c = 8'(MIN_HEIGHT_SEG);
    end else if (height_segments > 8'(MAX_SEGMENTS)) begin
      h_c = 8'(MAX_SEGMENTS);
    end else begin
      h_c = height_segments;
    end
    col_c = (s_axis_tdata[7:0] > w_c) ? w_c : s_axis_tdata[7:0];
    row_c = (s_axis_tdata[15:8] > h_c) ? h_c : s_axis_tdata[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_col <= col_c;
      e_row <= row_c;
      e_w   <= w_c;
      e_h   <= h_c;
    end
  end

  // phi = round(col * 2^16 / w), theta = round(row * 2^15 / h), as turn fractions
  uvs_div u_div_phi (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_num    ({e_col, 16'h0000} + 24'(e_w >> 1)),
    .in_den    (e_w),
    .out_valid (phi_dv),
    .out_quo   (phi)
  );

  uvs_div u_div_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_num    ({1'b0, e_row, 15'h0000} + 24'(e_h >> 1)),
    .in_den    (e_h),
    .out_valid (th_dv),
    .out_quo   (theta)
  );

  uvs_trig u_trig_phi (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (phi_dv),
    .in_angle  (phi),
    .out_valid (phi_tv),
    .out_sin   (sp),
    .out_cos   (cp)
  );

  uvs_trig u_trig_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (th_dv),
    .in_angle  (theta),
    .out_valid (th_tv),
    .out_sin   (st),
    .out_cos   (ct)
  );

  assign t_valid = phi_tv && th_tv;

  // cell indices and triangle flags, delayed to meet the arithmetic
  always_comb begin
    wp1     = {1'b0, e_w} + 9'd1;
    colr    = (e_col < e_w) ? e_col + 8'd1 : e_w;
    rowd    = (e_row < e_h) ? e_row + 8'd1 : e_h;
    in_cell = (e_col < e_w) && (e_row < e_h);
    side_next.idx_top_left     = 16'(17'(e_row) * 17'(wp1) + 17'(e_col));
    side_next.idx_top_right    = 16'(17'(e_row) * 17'(wp1) + 17'(colr));
    side_next.idx_bottom_left  = 16'(17'(rowd) * 17'(wp1) + 17'(e_col));
    side_next.idx_bottom_right = 16'(17'(rowd) * 17'(wp1) + 17'(colr));
    // no top triangle at the north pole row, no bottom one at the south pole row
    side_next.upper_tri_valid  = in_cell && (e_row != 8'd0);
    side_next.lower_tri_valid  = in_cell && (e_row != e_h - 8'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= side_next;
      for (int i = 1; i < SB_LEN; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= t_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // unit direction products in q60, and cos theta times radius
      p1_cst <= 64'(cp) * 64'(st);
      p1_sst <= 64'(sp) * 64'(st);
      p1_ctr <= 64'(ct) * 64'(rad_s);
      p1_ct  <= ct;
      // back to q30, pos_y to q8.8
      p2_px   <= 32'(-rnd_shift30(p1_cst));
      p2_pz   <= 32'(rnd_shift30(p1_sst));
      p2_posy <= 17'(rnd_shift30(p1_ctr));
      p2_ct   <= p1_ct;
      // scale by radius, normals to q1.14
      p3_pxr  <= 64'(p2_px) * 64'(rad_s);
      p3_pzr  <= 64'(p2_pz) * 64'(rad_s);
      p3_posy <= p2_posy;
      p3_nx   <= 16'(rnd_shift16(64'(p2_px)));
      p3_ny   <= 16'(rnd_shift16(64'(p2_ct)));
      p3_nz   <= 16'(rnd_shift16(64'(p2_pz)));
      // output register
      pos_x    <= 17'(rnd_shift30(p3_pxr));
      pos_y    <= p3_posy;
      pos_z    <= 17'(rnd_shift30(p3_pzr));
      norm_x   <= p3_nx;
      norm_y   <= p3_ny;
      norm_z   <= p3_nz;
      out_side <= sb[SB_LEN-1];
    end
  end

  assign m_axis_tvalid = p4_valid;
  assign m_axis_tdata  = {3'b000,
                          out_side.lower_tri_valid, out_side.upper_tri_valid,
                          out_side.idx_bottom_right, out_side.idx_bottom_left,
                          out_side.idx_top_right, out_side.idx_top_left,
                          norm_z, norm_y, norm_x,
                          pos_z, pos_y, pos_x};

`ifndef SYNTHESIS
  // backpressure reaches the input only through a blocked output register
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // an accepted transaction is in the entry stage in the next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> e_valid)
    else $error("accepted transaction missing from entry stage");

  // both trig lanes carry the same item
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    phi_tv == th_tv)
    else $error("trig lanes out of step");

  // a cell with a triangle always has its right neighbor one index up
  a_cell_right_index: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_side.upper_tri_valid || out_side.lower_tri_valid))
      |-> (out_side.idx_top_right == out_side.idx_top_left + 16'd1))
    else $error("triangle cell with bad right index");

  // unit normal y component stays within one
  a_norm_y_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (norm_y <= 16'sd16384 && norm_y >= -16'sd16384))
    else $error("normal y out of range");
`endif

endmodule

// ===== rtl/uvs_div.sv =====
// pipelined restoring divider for the angle fractions, two quotient bits per stage
module uvs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [23:0] in_num,
  input  logic [7:0]  in_den,
  output logic        out_valid,
  output logic [15:0] out_quo
);
  import uvs_pkg::*;

  localparam int S = DIV_STAGES;

  logic        v   [S];
  logic [7:0]  rem [S];
  logic [23:0] num [S];
  logic [7:0]  den [S];

  // num shifts left, quotient bits enter at the bottom
  function automatic logic [31:0] div_step(input logic [7:0] r_in, input logic [23:0] n_in,
                                           input logic [7:0] d);
    logic [7:0]  r;
    logic [23:0] n;
    logic [8:0]  t;
    r = r_in;
    n = n_in;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t = {r, n[23]};
      n = {n[22:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r = 8'(t - {1'b0, d});
        n[0] = 1'b1;
      end else begin
        r = t[7:0];
      end
    end
    return {r, n};
  endfunction

  for (genvar g = 0; g < S; g++) begin : g_stage
    logic        v_in;
    logic [7:0]  r_in;
    logic [23:0] n_in;
    logic [7:0]  d_in;
    logic [31:0] res;

    if (g == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = 8'd0;
      assign n_in = in_num;
      assign d_in = in_den;
    end else begin : g_rest
      assign v_in = v[g-1];
      assign r_in = rem[g-1];
      assign n_in = num[g-1];
      assign d_in = den[g-1];
    end

    assign res = div_step(r_in, n_in, d_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (en) begin
        v[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= res[31:24];
        num[g] <= res[23:0];
        den[g] <= d_in;
      end
    end
  end

  assign out_valid = v[S-1];
  assign out_quo   = num[S-1][15:0];

endmodule

// ===== rtl/uvs_trig.sv =====
// pipelined sine and cosine of a 16 bit turn fraction, taylor series in q30
module uvs_trig (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [15:0]   in_angle,
  output logic          out_valid,
  output uvs_pkg::q30_t out_sin,
  output uvs_pkg::q30_t out_cos
);
  import uvs_pkg::*;

  localparam int HS = HORNER_STEPS;

  typedef struct packed {
    logic [1:0]  q;
    logic [30:0] x;
    logic [31:0] x2;
    q30_t        ts;
    q30_t        tc;
  } hctx_t;

  // setup stages
  logic        s1_v, s2_v, s3_v;
  logic [1:0]  s1_q, s2_q;
  logic [30:0] s1_x, s2_x;
  logic [61:0] s2_sq;
  hctx_t       s3_ctx;

  // horner step stages
  logic        a_v [HS];
  hctx_t       a_ctx [HS];
  logic [62:0] a_pc [HS];
  logic [62:0] a_ps [HS];
  logic        b_v [HS];
  hctx_t       b_ctx [HS];
  logic [31:0] b_nc [HS];
  logic [63:0] b_mc [HS];
  logic [31:0] b_ns [HS];
  logic [63:0] b_ms [HS];
  logic        c_v [HS];
  hctx_t       c_ctx [HS];

  // finishing stages
  logic        f1_v;
  logic [1:0]  f1_q;
  logic [61:0] f1_sx;
  q30_t        f1_tc;
  logic        f2_v;
  q30_t        f2_sin, f2_cos;
  q30_t        s_cl, c_cl, f2_sin_next, f2_cos_next;
  logic [31:0] s_raw;

  // reciprocal estimate plus one correction step
  function automatic logic [31:0] odd_div(input logic [31:0] np, input logic [63:0] m,
                                          input logic [5:0] odd);
    logic [31:0] q0;
    logic [37:0] r;
    q0 = m[63:32];
    r  = 38'(np) - 38'(q0) * 38'(odd);
    return (r >= 38'(odd)) ? q0 + 32'd1 : q0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      f1_v <= c_v[HS-1];
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q      <= in_angle[15:14];
      s1_x      <= 31'((45'(in_angle[13:0]) * 45'(HALF_PI_Q30)) >> 14);
      s2_q      <= s1_q;
      s2_x      <= s1_x;
      s2_sq     <= 62'(s1_x) * 62'(s1_x);
      s3_ctx.q  <= s2_q;
      s3_ctx.x  <= s2_x;
      s3_ctx.x2 <= 32'((s2_sq + (62'd1 << 29)) >> 30);
      s3_ctx.ts <= ONE_Q30;
      s3_ctx.tc <= ONE_Q30;
    end
  end

  for (genvar k = 0; k < HS; k++) begin : g_step
    logic  v_in;
    hctx_t ctx_in;
    hctx_t c_next;
    logic [31:0] qc, qs;

    if (k == 0) begin : g_first
      assign v_in   = s3_v;
      assign ctx_in = s3_ctx;
    end else begin : g_rest
      assign v_in   = c_v[k-1];
      assign ctx_in = c_ctx[k-1];
    end

    assign qc = odd_div(b_nc[k], b_mc[k], 6'(COS_ODD[k]));
    assign qs = odd_div(b_ns[k], b_ms[k], 6'(SIN_ODD[k]));

    // t = 1 - quotient
    always_comb begin
      c_next    = b_ctx[k];
      c_next.tc = ONE_Q30 - $signed(qc);
      if (k < SIN_STEPS) begin
        c_next.ts = ONE_Q30 - $signed(qs);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[k] <= 1'b0;
        b_v[k] <= 1'b0;
        c_v[k] <= 1'b0;
      end else if (en) begin
        a_v[k] <= v_in;
        b_v[k] <= a_v[k];
        c_v[k] <= b_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // x2 * t
        a_ctx[k] <= ctx_in;
        a_pc[k]  <= 63'(ctx_in.x2) * 63'(ctx_in.tc[30:0]);
        a_ps[k]  <= 63'(ctx_in.x2) * 63'(ctx_in.ts[30:0]);
        // drop q30 and the power of two, then multiply by the odd reciprocal
        b_ctx[k] <= a_ctx[k];
        b_nc[k]  <= 32'(a_pc[k] >> (30 + COS_SHIFT[k]));
        b_mc[k]  <= 64'(32'(a_pc[k] >> (30 + COS_SHIFT[k]))) * 64'(COS_RECIP[k]);
        b_ns[k]  <= 32'(a_ps[k] >> (30 + SIN_SHIFT[k]));
        b_ms[k]  <= 64'(32'(a_ps[k] >> (30 + SIN_SHIFT[k]))) * 64'(SIN_RECIP[k]);
        c_ctx[k] <= c_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_q  <= c_ctx[HS-1].q;
      f1_sx <= 62'(c_ctx[HS-1].x) * 62'(c_ctx[HS-1].ts[30:0]);
      f1_tc <= c_ctx[HS-1].tc;
      f2_sin <= f2_sin_next;
      f2_cos <= f2_cos_next;
    end
  end

  // clamp to [0, 1] and fold into the quadrant
  always_comb begin
    s_raw = 32'(f1_sx >> 30);
    s_cl  = (s_raw > 32'(ONE_Q30)) ? ONE_Q30 : $signed(s_raw);
    if (f1_tc < 0) begin
      c_cl = '0;
    end else if (f1_tc > ONE_Q30) begin
      c_cl = ONE_Q30;
    end else begin
      c_cl = f1_tc;
    end
    unique case (f1_q)
      2'd0: begin
        f2_sin_next = s_cl;
        f2_cos_next = c_cl;
      end
      2'd1: begin
        f2_sin_next = c_cl;
        f2_cos_next = -s_cl;
      end
      2'd2: begin
        f2_sin_next = -s_cl;
        f2_cos_next = -c_cl;
      end
      default: begin
        f2_sin_next = -c_cl;
        f2_cos_next = s_cl;
      end
    endcase
  end

  assign out_valid = f2_v;
  assign out_sin   = f2_sin;
  assign out_cos   = f2_cos;

endmodule
